// File: design/crc32c_pkg.sv
// ----------------------------------------------------------------------------
// crc32c_pkg: shared constants and helpers for the CRC-32C engine
// Reflected Castagnoli polynomial, the register mask, and an elaboration-time
// helper that builds the columns of the GF(2) matrices used by lanes and merge.
// ----------------------------------------------------------------------------
package crc32c_pkg;

  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcMask = 32'hFFFFFFFF;
  localparam int unsigned MaxBytes = 16;
  localparam int unsigned MaxShiftBits = 8 * MaxBytes;
  localparam int unsigned ByteW = 8;
  localparam int unsigned DataBytes = 8;

  typedef logic [31:0] crc_t;

  typedef struct packed {
    logic first;
    logic last;
  } word_ctl_t;

  // Run the reflected update over nbits zero input bits. Called only with
  // constant arguments to build matrix columns.
  function automatic crc_t crc_zero_bits(crc_t r_in, int unsigned nbits);
    crc_t r;
    r = r_in;
    for (int unsigned k = 0; k < MaxShiftBits + ByteW; k++) begin
      if (k < nbits) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
    end
    return r;
  endfunction

endpackage

// File: design/crc32c_lane.sv
// ----------------------------------------------------------------------------
// crc32c_lane: contribution of one message byte
// Folds one byte into a zero register and advances it by SHIFT_BYTES further
// zero bytes, as a constant XOR network over the byte's bits.
// ----------------------------------------------------------------------------
module crc32c_lane
  import crc32c_pkg::*;
#(
  parameter int unsigned SHIFT_BYTES = 0
) (
  input  logic [ByteW-1:0] byte_i,
  output crc_t             contrib_o
);

  crc_t term [ByteW];

  for (genvar gb = 0; gb < ByteW; gb++) begin : g_col
    localparam crc_t Col = crc_zero_bits(crc_t'(1) << gb, ByteW * (SHIFT_BYTES + 1));
    assign term[gb] = byte_i[gb] ? Col : '0;
  end

  always_comb begin
    contrib_o = '0;
    for (int b = 0; b < ByteW; b++) begin
      contrib_o = contrib_o ^ term[b];
    end
  end

endmodule

// File: design/crc32c_merge.sv
// ----------------------------------------------------------------------------
// crc32c_merge: combine the running register with the lane results
// Advances the base register by the word's byte count through zero-byte
// matrices and XORs in the merged lane contribution.
// ----------------------------------------------------------------------------
module crc32c_merge
  import crc32c_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 8,
  localparam int unsigned CntW = $clog2(MAX_BYTES + 1)
) (
  input  crc_t            base_i,
  input  logic [CntW-1:0] cnt_i,
  input  crc_t            contrib_i,
  output crc_t            crc_o
);

  crc_t adv [MAX_BYTES + 1];

  for (genvar gn = 0; gn <= MAX_BYTES; gn++) begin : g_adv
    crc_t term [32];
    for (genvar gi = 0; gi < 32; gi++) begin : g_col
      localparam crc_t Col = crc_zero_bits(crc_t'(1) << gi, ByteW * gn);
      assign term[gi] = base_i[gi] ? Col : '0;
    end
    always_comb begin
      adv[gn] = '0;
      for (int i = 0; i < 32; i++) begin
        adv[gn] = adv[gn] ^ term[i];
      end
    end
  end

  crc_t adv_sel;

  always_comb begin
    adv_sel = '0;
    for (int n = 0; n <= MAX_BYTES; n++) begin
      if (cnt_i == CntW'(n)) begin
        adv_sel = adv[n];
      end
    end
    crc_o = adv_sel ^ contrib_i;
  end

endmodule

// File: design/crc32c_stream_engine_unit.sv
// ----------------------------------------------------------------------------
// crc32c_stream_engine_unit: streaming CRC-32C over words of message bytes
// A last word's CRC passes the lane stage register, then the output register.
// Throughput: one word per cycle; a last word waits while the output is full and
// stalled. The loop is the running register through merge's byte-count matrices.
// Reset: running register all ones, lane stage and output register empty.
// ----------------------------------------------------------------------------
module crc32c_stream_engine_unit
  import crc32c_pkg::*;
#(
  parameter int unsigned BYTES_PER_WORD = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] crc_value_o
);

  localparam int unsigned CntW = $clog2(BYTES_PER_WORD + 1);
  localparam int unsigned CmpW = 5;

  // Saturate the count and right-align the valid bytes into the lanes, so
  // lane j always sits BYTES_PER_WORD-1-j bytes from the end of the word.
  logic [CntW-1:0]  cnt_sat;
  logic [ByteW-1:0] lane_byte [BYTES_PER_WORD];
  crc_t             lane_contrib [BYTES_PER_WORD];
  crc_t             word_contrib;

  always_comb begin
    if ({1'b0, byte_count_i} > CmpW'(BYTES_PER_WORD)) begin
      cnt_sat = CntW'(BYTES_PER_WORD);
    end else begin
      cnt_sat = CntW'(byte_count_i);
    end
  end

  always_comb begin
    int k;
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      k = j + int'(cnt_sat) - int'(BYTES_PER_WORD);
      lane_byte[j] = '0;
      if (k >= 0 && k < DataBytes) begin
        lane_byte[j] = data_bytes_i[ByteW * k[2:0] +: ByteW];
      end
    end
  end

  for (genvar gj = 0; gj < BYTES_PER_WORD; gj++) begin : g_lane
    crc32c_lane #(
      .SHIFT_BYTES(BYTES_PER_WORD - 1 - gj)
    ) u_lane (
      .byte_i   (lane_byte[gj]),
      .contrib_o(lane_contrib[gj])
    );
  end

  always_comb begin
    word_contrib = '0;
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      word_contrib = word_contrib ^ lane_contrib[j];
    end
  end

  // Lane stage register
  logic            s1_valid_q;
  crc_t            s1_contrib_q;
  logic [CntW-1:0] s1_cnt_q;
  word_ctl_t       s1_ctl_q;
  crc_t            s1_seed_q;

  crc_t crc_q, crc_d, crc_base;
  logic out_valid_q;
  crc_t out_crc_q;
  logic s1_fire;
  logic in_fire;

  // Hold a last word while the output register is still occupied.
  assign s1_fire    = s1_valid_q && (!s1_ctl_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign crc_base = s1_ctl_q.first ? (s1_seed_q ^ CrcMask) : crc_q;

  crc32c_merge #(
    .MAX_BYTES(BYTES_PER_WORD)
  ) u_merge (
    .base_i   (crc_base),
    .cnt_i    (s1_cnt_q),
    .contrib_i(s1_contrib_q),
    .crc_o    (crc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_contrib_q   <= word_contrib;
      s1_cnt_q       <= cnt_sat;
      s1_ctl_q.first <= first_i;
      s1_ctl_q.last  <= last_i;
      s1_seed_q      <= seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcMask;
    end else if (s1_fire) begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_ctl_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_ctl_q.last) begin
      out_crc_q <= crc_d ^ CrcMask;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

endmodule

// File: verif/crc32c_stream_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// crc32c_stream_engine_unit_tb: self-checking bench for the CRC-32C engine
// Drives words of message bytes through the input channel, predicts each CRC
// that a last word produces, and compares every output beat in order. Covers
// headless words after reset, zero and oversized byte counts, restarts,
// continuation past a last word, random messages with random idling on both
// channels, a full drain pause, and a back-to-back stream at the end.
// ----------------------------------------------------------------------------
module crc32c_stream_engine_unit_tb;
  import crc32c_pkg::*;

  localparam int unsigned WordBytes  = DataBytes;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] data_bytes_i;
  logic [3:0]  byte_count_i;
  logic        first_i;
  logic        last_i;
  logic [31:0] seed_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] crc_value_o;

  crc_t        crc_expect_q[$];
  crc_t        crc_running;
  bit          tx_gap_en;
  bit          rx_stall_en;
  int unsigned mismatch_count;
  int unsigned words_accepted;
  int unsigned crcs_checked;
  int unsigned messages_sent;
  int unsigned cycle_count;

  crc32c_stream_engine_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_bytes_i(data_bytes_i),
    .byte_count_i(byte_count_i),
    .first_i     (first_i),
    .last_i      (last_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .crc_value_o (crc_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               crc_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Fold the valid bytes of one word into the running register, byte 0 first.
  // Counts above the word size saturate.
  function automatic crc_t crc_fold_word(crc_t acc_in, logic [63:0] data,
                                         logic [3:0] count);
    crc_t        acc;
    int unsigned nbytes;
    acc = acc_in;
    nbytes = (count > WordBytes) ? WordBytes : count;
    for (int unsigned i = 0; i < WordBytes; i++) begin
      if (i < nbytes) begin
        acc = acc ^ crc_t'(data[8*i +: 8]);
        for (int unsigned b = 0; b < 8; b++) begin
          acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
        end
      end
    end
    return acc;
  endfunction

  // Track accepted beats on both channels; compare each CRC with the oldest one due.
  always @(posedge clk_i or negedge rst_ni) begin
    crc_t exp_crc;
    if (!rst_ni) begin
      crc_running = CrcMask;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (crc_expect_q.size() == 0) begin
          $display("%0t: unexpected crc beat: expected none, actual %08h", $time,
                   crc_value_o);
          mismatch_count++;
        end else begin
          exp_crc = crc_expect_q.pop_front();
          crcs_checked++;
          if (crc_value_o !== exp_crc) begin
            $display("%0t: crc_value mismatch: expected %08h, actual %08h", $time,
                     exp_crc, crc_value_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        words_accepted++;
        if (first_i) crc_running = seed_i ^ CrcMask;
        crc_running = crc_fold_word(crc_running, data_bytes_i, byte_count_i);
        if (last_i) crc_expect_q.push_back(crc_running ^ CrcMask);
      end
    end
  end

  // Receiver side: stall in random bursts while enabled, otherwise always ready.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rx_stall_en) begin
        stall_left = 0;
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                           input logic first, input logic last,
                           input logic [31:0] seed);
    int unsigned gap;
    gap = 0;
    if (tx_gap_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_bytes_i <= data;
    byte_count_i <= count;
    first_i      <= first;
    last_i       <= last;
    seed_i       <= seed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [3:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return 4'($urandom_range(1, WordBytes));
    if (r == 16) return 4'd0;
    return 4'($urandom_range(WordBytes + 1, 15));
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One message of 1 to 6 words; now and then a broken one with random markers.
  task automatic send_message(input bit broken);
    int unsigned nwords;
    logic        f;
    logic        l;
    nwords = $urandom_range(1, 6);
    for (int unsigned w = 0; w < nwords; w++) begin
      f = broken ? 1'($urandom_range(0, 1)) : (w == 0);
      l = broken ? 1'($urandom_range(0, 1)) : (w == nwords - 1);
      send_word(pick_data(), pick_count(), f, l, $urandom());
    end
    messages_sent++;
  endtask

  // Words with no first marker fold from the reset value of the register.
  task automatic test_headless_after_reset();
    send_word('1, 4'd8, 1'b0, 1'b0, 32'hA5A5_A5A5);
    send_word('0, 4'd3, 1'b0, 1'b1, 32'h5A5A_5A5A);
    messages_sent++;
  endtask

  task automatic test_field_extremes();
    // zero count gives the seed back
    send_word(64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b1, 32'hDEAD_BEEF);
    send_word('1, 4'd0, 1'b1, 1'b1, '1);
    send_word('0, 4'd8, 1'b1, 1'b1, '0);
    send_word('1, 4'd8, 1'b1, 1'b1, '1);
    send_word(64'h0000_0000_0000_00A5, 4'd1, 1'b1, 1'b1, 32'h1234_5678);
    // counts past the word size saturate
    send_word(64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b1, '0);
    send_word(64'hFEDC_BA98_7654_3210, 4'd12, 1'b1, 1'b1, 32'h8000_0001);
    send_word('1, 4'd15, 1'b1, 1'b1, 32'h7FFF_FFFE);
    // standard check string "123456789"
    send_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, '0);
    send_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1, '1);
    messages_sent += 9;
  endtask

  task automatic test_restart_and_continuation();
    // keep folding past a last word without a new first
    send_word(64'h8000_0000_0000_0001, 4'd4, 1'b0, 1'b1, 32'hFFFF_0000);
    // empty middle words leave the register alone
    send_word(64'h1111_2222_3333_4444, 4'd5, 1'b1, 1'b0, 32'h0F0F_0F0F);
    send_word('1, 4'd0, 1'b0, 1'b0, '1);
    send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, '0);
    // a second first in mid-message reloads the seed
    send_word(64'hCAFE_F00D_1234_5678, 4'd5, 1'b1, 1'b0, 32'h0000_FFFF);
    send_word(64'hAAAA_5555_AAAA_5555, 4'd2, 1'b1, 1'b1, 32'hF0F0_F0F0);
    send_word(64'h5555_AAAA_5555_AAAA, 4'd7, 1'b1, 1'b1, 32'h3C3C_C3C3);
    messages_sent += 4;
  endtask

  task automatic test_random_messages(input int unsigned nwords);
    int unsigned start;
    start = words_accepted;
    while (words_accepted - start < nwords) begin
      tx_gap_en   = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      send_message($urandom_range(0, 9) == 0);
    end
  endtask

  // Hold the sender until every CRC in flight has come out, then resume.
  task automatic test_drain_pause();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
    repeat (3) send_message(1'b0);
    drain_results();
    repeat (3) send_message(1'b0);
  endtask

  task automatic test_back_to_back(input int unsigned nwords);
    int unsigned start;
    tx_gap_en   = 1'b0;
    rx_stall_en = 1'b0;
    start = words_accepted;
    while (words_accepted - start < nwords) send_message($urandom_range(0, 19) == 0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_bytes_i   = '0;
    byte_count_i   = '0;
    first_i        = 1'b0;
    last_i         = 1'b0;
    seed_i         = '0;
    tx_gap_en      = 1'b0;
    rx_stall_en    = 1'b0;
    mismatch_count = 0;
    words_accepted = 0;
    crcs_checked   = 0;
    messages_sent  = 0;
    cycle_count    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_headless_after_reset();
    test_field_extremes();
    test_restart_and_continuation();
    test_random_messages(700);
    test_drain_pause();
    test_random_messages(600);
    test_back_to_back(260);

    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d words in %0d messages, %0d CRC beats compared", words_accepted,
             messages_sent, crcs_checked);
    $display("byte counts 0 to 15, headless and restarted messages, idling on both sides");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/crc32c_pkg.sv
design/crc32c_lane.sv
design/crc32c_merge.sv
design/crc32c_stream_engine_unit.sv
verif/crc32c_stream_engine_unit_tb.sv
